// File: sv/kpt_pkg.sv
package kpt_pkg;

  // field widths
  localparam int RANK_W      = 16;
  localparam int NODE_CNT_W  = 17;
  localparam int BRANCH_W    = 7;
  localparam int PARENT_W    = 17;
  localparam int DESC_W      = 16;
  localparam int DEPTH_W     = 5;
  localparam int OUT_TDATA_W = 48;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = NODE_CNT_W;
  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BRANCHING  = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic start;   // capture rank and clamped config, reset the walk
    logic grow;    // one more level of the full tree size table
    logic level;   // step down one level, fetch the child subtree size
    logic div;     // one quotient bit of rel / child
    logic finish;  // load the result register
  } kpt_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic oob;        // rank not below node count
    logic grow_more;  // full tree size still below node count
    logic rank_zero;  // query is the root
    logic bit_last;   // current quotient bit is bit 0
    logic found;      // remainder after this bit is zero
    logic out_free;   // result register can take a new result
  } kpt_sts_t;

endpackage

// File: sv/kpt_ctrl.sv
module kpt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  kpt_pkg::kpt_sts_t sts,
  output kpt_pkg::kpt_cmd_t cmd
);
  import kpt_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DEPTH  = 3'd1;
  localparam logic [2:0] S_LEVEL  = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.start = 1'b1;
          state_nxt = S_DEPTH;
        end
      end
      S_DEPTH: begin
        if (sts.oob) begin
          state_nxt = S_FINISH;
        end else if (sts.grow_more) begin
          cmd.grow = 1'b1;
        end else if (sts.rank_zero) begin
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_LEVEL;
        end
      end
      S_LEVEL: begin
        cmd.level = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div = 1'b1;
        if (sts.bit_last) begin
          state_nxt = sts.found ? S_FINISH : S_LEVEL;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: sv/kpt_datapath.sv
module kpt_datapath #(
  parameter int MAX_NODES     = 65536,
  parameter int MAX_BRANCHING = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  input  logic [kpt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [kpt_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [kpt_pkg::RANK_W-1:0]          in_rank,
  input  kpt_pkg::kpt_cmd_t                   cmd,
  output kpt_pkg::kpt_sts_t                   sts,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [kpt_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                out_tuser
);
  import kpt_pkg::*;

  localparam longint unsigned SPAN =
    longint'(MAX_NODES) * longint'(MAX_BRANCHING) + longint'(2);
  localparam int WW   = $clog2(MAX_BRANCHING + 1);
  localparam int SW   = $clog2(SPAN);
  localparam int DMAX = $clog2(MAX_NODES);
  localparam int DW   = $clog2(DMAX + 1);
  localparam int QW   = $clog2(WW);
  localparam int TW   = SW + WW;
  localparam int XW   = ((SW > NODE_CNT_W) ? SW : NODE_CNT_W) + 1;

  // configuration registers
  logic [NODE_CNT_W-1:0] node_cnt_r;
  logic [BRANCH_W-1:0]   branch_r;

  // per-query registers
  logic [RANK_W-1:0]     rank_r;
  logic [NODE_CNT_W-1:0] n_r;
  logic [WW-1:0]         w_r;
  logic [QW-1:0]         qtop_r;
  logic [SW-1:0]         s_r;
  logic [DW-1:0]         d_r;
  logic [DW-1:0]         lvl_r;
  logic [SW-1:0]         rel_r;
  logic [SW-1:0]         child_r;
  logic [QW-1:0]         bit_r;
  logic [RANK_W-1:0]     node_r;
  logic [SW-1:0]         stab_r [0:DMAX];

  // result register
  logic                  out_vld_r;
  logic                  res_valid_r;
  logic [PARENT_W-1:0]   res_parent_r;
  logic [DESC_W-1:0]     res_desc_r;
  logic [DEPTH_W-1:0]    res_ndepth_r;
  logic [DEPTH_W-1:0]    res_tdepth_r;

  logic [NODE_CNT_W-1:0] n_c;
  logic [WW-1:0]         w_c;
  logic [WW-1:0]         wm1;
  logic [QW-1:0]         qtop_c;
  logic [TW-1:0]         prod;
  logic [SW-1:0]         s_grow;
  logic [DW-1:0]         tidx;
  logic [TW-1:0]         trial;
  logic                  ge;
  logic [SW-1:0]         rem_new;
  logic [XW-1:0]         dsum;
  logic                  res_valid_c;
  logic [PARENT_W-1:0]   res_parent_c;
  logic [DESC_W-1:0]     res_desc_c;
  logic [DEPTH_W-1:0]    res_ndepth_c;
  logic [DEPTH_W-1:0]    res_tdepth_c;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_cnt_r <= NODE_CNT_W'(1);
      branch_r   <= BRANCH_W'(2);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_NODE_COUNT: node_cnt_r <= cfg_data;
        REG_BRANCHING:  branch_r   <= cfg_data[BRANCH_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp config and find the top quotient bit of the branching factor
  always_comb begin
    n_c = node_cnt_r;
    if (32'(node_cnt_r) > MAX_NODES) n_c = NODE_CNT_W'(MAX_NODES);
    if (branch_r < BRANCH_W'(2)) begin
      w_c = WW'(2);
    end else if (32'(branch_r) > MAX_BRANCHING) begin
      w_c = WW'(MAX_BRANCHING);
    end else begin
      w_c = WW'(branch_r);
    end
    wm1    = w_c - WW'(1);
    qtop_c = '0;
    for (int i = 0; i < WW; i++) begin
      if (wm1[i]) qtop_c = QW'(i);
    end
  end

  // next full tree size: w * S + 1
  assign prod   = TW'(w_r) * TW'(s_r);
  assign s_grow = prod[SW-1:0] + SW'(1);

  // child subtree size one level further down
  assign tidx = d_r - lvl_r - DW'(1);

  // one restoring division step
  assign trial   = TW'(child_r) << bit_r;
  assign ge      = TW'(rel_r) >= trial;
  assign rem_new = ge ? SW'(TW'(rel_r) - trial) : rel_r;

  // status
  always_comb begin
    sts           = '0;
    sts.oob       = XW'(rank_r) >= XW'(n_r);
    sts.grow_more = XW'(s_r) < XW'(n_r);
    sts.rank_zero = rank_r == '0;
    sts.bit_last  = bit_r == '0;
    sts.found     = rem_new == '0;
    sts.out_free  = !out_vld_r || out_tready;
  end

  // walk registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rank_r    <= in_rank;
      n_r       <= n_c;
      w_r       <= w_c;
      qtop_r    <= qtop_c;
      s_r       <= SW'(1);
      d_r       <= '0;
      lvl_r     <= '0;
      node_r    <= '0;
      rel_r     <= SW'(in_rank) - SW'(1);
      stab_r[0] <= SW'(1);
    end
    if (cmd.grow) begin
      s_r                    <= s_grow;
      d_r                    <= d_r + DW'(1);
      stab_r[d_r + DW'(1)]   <= s_grow;
    end
    if (cmd.level) begin
      child_r <= stab_r[tidx];
      lvl_r   <= lvl_r + DW'(1);
      bit_r   <= qtop_r;
    end
    if (cmd.div) begin
      bit_r <= bit_r - QW'(1);
      if (bit_r == '0 && rem_new != '0) begin
        // rank lies inside the chosen child: descend into it
        rel_r  <= rem_new - SW'(1);
        node_r <= RANK_W'(XW'(rank_r) - XW'(rem_new));
      end else begin
        rel_r <= rem_new;
      end
    end
  end

  // result fields
  always_comb begin
    res_valid_c  = 1'b0;
    res_parent_c = '0;
    res_desc_c   = '0;
    res_ndepth_c = '0;
    res_tdepth_c = '0;
    dsum         = XW'(rank_r) + XW'(child_r) - XW'(1);
    if (!sts.oob) begin
      res_valid_c  = 1'b1;
      res_tdepth_c = DEPTH_W'(d_r);
      if (sts.rank_zero) begin
        res_parent_c = '1;
        res_desc_c   = DESC_W'(n_r - NODE_CNT_W'(1));
      end else begin
        res_parent_c = PARENT_W'(node_r);
        res_ndepth_c = DEPTH_W'(lvl_r);
        // clamp the subtree to the last node
        if (dsum >= XW'(n_r)) begin
          res_desc_c = DESC_W'(XW'(n_r) - XW'(rank_r) - XW'(1));
        end else begin
          res_desc_c = DESC_W'(child_r - SW'(1));
        end
      end
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.finish) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_valid_r  <= res_valid_c;
      res_parent_r <= res_parent_c;
      res_desc_r   <= res_desc_c;
      res_ndepth_r <= res_ndepth_c;
      res_tdepth_r <= res_tdepth_c;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = res_valid_r;
  assign out_tdata  = {5'b0, res_tdepth_r, res_ndepth_r, res_desc_r, res_parent_r};

endmodule

// File: sv/kary_preorder_tree_position_core.sv
// channel | direction | signals                            | transfer when
// in      | input     | in_tvalid, in_tready, in_tdata     | in_tvalid & in_tready
// out     | output    | out_tvalid, out_tready, out_tdata,  | out_tvalid & out_tready
//         |           | out_tuser                          |
// cfg     | input     | cfg_valid, cfg_ready, cfg_index,   | cfg_valid & cfg_ready
//         |           | cfg_data                           |
//
// one query at a time: one multiply per level of the tree depth builds the full subtree
// size table, then at each level of the node depth one restoring division bit per cycle,
// over the bit count of branching-1, picks the child
// out of range ranks and the root skip the descent
// reset clears the walk controller and the result valid, node_count 1, branching 2
// a stalled result holds in the output register while the next query is taken
module kary_preorder_tree_position_core #(
  parameter int MAX_NODES     = 65536,
  parameter int MAX_BRANCHING = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [kpt_pkg::RANK_W-1:0]      in_tdata,   // [15:0] rank
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [16:0] parent_rank, [32:17] descendants, [37:33] node_depth,
  // [42:38] tree_depth, [47:43] zero
  output logic [kpt_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tuser,  // [0] valid_res
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [kpt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kpt_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import kpt_pkg::*;

  kpt_cmd_t cmd;
  kpt_sts_t sts;

  // configuration writes are always taken
  assign cfg_ready = 1'b1;

  // walk controller
  kpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // size table, divider and result register
  kpt_datapath #(
    .MAX_NODES     (MAX_NODES),
    .MAX_BRANCHING (MAX_BRANCHING)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_rank    (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// File: sv/kpt_checker.sv
module kpt_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [kpt_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tuser
);
  import kpt_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // one query at a time
  a_one_query: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a query is in flight");

  // out of range result is all zero
  a_oob_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("out of range result carries data");

  // node never deeper than the tree
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[37:33] <= out_tdata[42:38])
    else $error("node depth above tree depth");

  // root and only the root has parent -1
  a_root: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> ((out_tdata[37:33] == '0) == (out_tdata[16:0] == '1)))
    else $error("root parent mismatch");

endmodule

bind kary_preorder_tree_position_core kpt_checker u_kpt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
